// ===== hw/rtl/scld_pkg.sv =====
package scld_pkg;

    // Received byte codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_E     = 8'd69;
    localparam logic [7:0] CH_F     = 8'd70;
    localparam logic [7:0] CH_N     = 8'd78;
    localparam logic [7:0] CH_O     = 8'd79;
    localparam logic [7:0] CH_LC_A  = 8'd97;
    localparam logic [7:0] CH_LC_Z  = 8'd122;
    localparam logic [7:0] CASE_OFS = 8'd32;

    // Configuration registers
    localparam int          CFG_IDX_W = 2;
    localparam int          CFG_W     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IVL = 2'd1;
    localparam logic [CFG_W-1:0]     MIN_IVL_RST = 16'd100;
    localparam logic [CFG_W-1:0]     MAX_IVL_RST = 16'd30000;

    // Decode window: the leading columns of the line
    localparam int WIN_LEN = 16;
    localparam int POS_W   = 4;

    // Accumulator: up to 99.9 s in ms
    localparam int ACC_W = 17;
    localparam int DIG_W = 4;

    localparam logic [POS_W-1:0] COL_SD_ARG  = 4'd3;
    localparam logic [POS_W-1:0] COL_STATE   = 4'd6;
    localparam logic [POS_W-1:0] COL_SECONDS = 4'd6;
    localparam logic [POS_W-1:0] COL_LOGGING = 4'd8;
    localparam logic [POS_W-1:0] COL_SEC_END = 4'd8;
    localparam logic [POS_W-1:0] COL_COUNT   = 4'd11;
    localparam logic [POS_W-1:0] COL_CNT_END = 4'd15;

    typedef enum logic [2:0] {
        PFX_READ_NOW,
        PFX_READBUF,
        PFX_SET_T,
        PFX_STATE,
        PFX_LOGGING,
        PFX_SD
    } t_pfx;

    localparam int NUM_PFX     = 6;
    localparam int PFX_MAX_LEN = 10;
    localparam int PFX_BITS    = 8 * PFX_MAX_LEN;

    localparam logic [PFX_BITS-1:0] PFX_S_READ_NOW = {"READ NOW", 16'h0000};
    localparam logic [PFX_BITS-1:0] PFX_S_READBUF  = "READBUFFER";
    localparam logic [PFX_BITS-1:0] PFX_S_SET_T    = {"SET T", 40'h0};
    localparam logic [PFX_BITS-1:0] PFX_S_STATE    = {"STATE", 40'h0};
    localparam logic [PFX_BITS-1:0] PFX_S_LOGGING  = {"LOGGING", 24'h0};
    localparam logic [PFX_BITS-1:0] PFX_S_SD       = {"SD", 64'h0};

    typedef enum logic {
        KIND_ECHO,
        KIND_CMD
    } t_kind;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_READ_NOW,
        CMD_READ_COUNT,
        CMD_SET_INTERVAL,
        CMD_SAMP_ON,
        CMD_SAMP_OFF,
        CMD_LOG_ON,
        CMD_LOG_OFF,
        CMD_SD_FLUSH,
        CMD_SD_EJECT
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_NUMBER,
        ST_OUT_OF_RANGE,
        ST_EXP_ON_OFF,
        ST_EXP_F_E,
        ST_UNRECOGNIZED
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PLAN,
        S_NUM,
        S_FRAC,
        S_SCALE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_kind       result_kind;
        logic [7:0]  echo_byte;
        t_cmd        command_code;
        logic [15:0] argument;
        logic        read_all;
        t_status     status;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [POS_W-1:0] pfx_len(input t_pfx p);
        logic [POS_W-1:0] n;
        unique case (p)
            PFX_READ_NOW: n = 4'd8;
            PFX_READBUF:  n = 4'd10;
            PFX_SET_T:    n = 4'd5;
            PFX_STATE:    n = 4'd5;
            PFX_LOGGING:  n = 4'd7;
            PFX_SD:       n = 4'd2;
            default:      n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] pfx_char(input t_pfx p, input logic [POS_W-1:0] k);
        logic [PFX_BITS-1:0] s;
        logic [7:0]          c;
        unique case (p)
            PFX_READ_NOW: s = PFX_S_READ_NOW;
            PFX_READBUF:  s = PFX_S_READBUF;
            PFX_SET_T:    s = PFX_S_SET_T;
            PFX_STATE:    s = PFX_S_STATE;
            PFX_LOGGING:  s = PFX_S_LOGGING;
            PFX_SD:       s = PFX_S_SD;
            default:      s = '0;
        endcase
        c = 8'h00;
        if (int'(k) < PFX_MAX_LEN) begin
            c = s[8 * (PFX_MAX_LEN - 1 - int'(k)) +: 8];
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/scld_rx_if.sv =====
interface scld_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/scld_res_if.sv =====
interface scld_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  echo_byte;
    logic [3:0]  command_code;
    logic [15:0] argument;
    logic        read_all;
    logic [2:0]  status;

    modport source (
        output valid, output result_kind, output echo_byte, output command_code,
        output argument, output read_all, output status, input ready
    );
    modport sink (
        input valid, input result_kind, input echo_byte, input command_code,
        input argument, input read_all, input status, output ready
    );
endinterface

// ===== hw/rtl/scld_mac.sv =====
module scld_mac
    import scld_pkg::*;
(
    input  logic [ACC_W-1:0] i_acc,
    input  logic [DIG_W-1:0] i_dig,
    output logic [ACC_W-1:0] o_acc
);

    logic [ACC_W+3:0] sum;

    // acc * 10 + digit as two shifted adds
    assign sum   = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0} + {(ACC_W)'(0), i_dig};
    assign o_acc = sum[ACC_W-1:0];

endmodule

// ===== hw/rtl/scld_line_store.sv =====
module scld_line_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_clr,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]       r_mem_q;
    logic             r_vld_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_mem_q <= r_mem[i_raddr];
    end

    // An entry never written since the last clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_vld_q <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_vld_q ? r_mem_q : 8'h00;

endmodule

// ===== hw/rtl/serial_command_line_decoder_core.sv =====
// Channel   Dir  Payload                                                   Item
// i_rx      in   rx_byte                                                   one received byte
// o_res     out  result_kind echo_byte command_code argument read_all      one result per byte
//                status
// i_cfg_*   in   i_cfg_idx (0 min interval, 1 max interval), i_cfg_data    one register write
//
// An ordinary byte or backspace is taken while idle and its echo is registered at once.
// Carriage return reads the first 16 columns from the line store one per cycle, then plans
// the number, makes up to five passes through the shared multiply-by-ten adder for it,
// then forms the result once the output register is free. The line store is cleared as
// that result is loaded. Synchronous active-low reset; o_res.ready low holds the result and stalls
// input until the output register can take the next result.
module serial_command_line_decoder_core
    import scld_pkg::*;
#(
    parameter int LINE_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    scld_rx_if.sink              i_rx,
    scld_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(LINE_DEPTH);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_idx, n_idx;
    logic [POS_W:0]     r_col, n_col;
    logic [7:0]         r_win [WIN_LEN];
    logic [7:0]         n_win [WIN_LEN];
    logic [NUM_PFX-1:0] r_match, n_match;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_is_set, n_is_set;
    logic               r_scale, n_scale;
    logic [CFG_W-1:0]   r_min, r_max;
    logic               r_out_valid;
    t_result            r_res, n_res;

    logic               out_free;
    logic               accept;
    logic               load_out;
    logic [7:0]         up_byte;
    logic               ls_we;
    logic               ls_clr;
    logic [AW-1:0]      ls_raddr;
    logic [7:0]         ls_rdata;
    logic [DIG_W-1:0]   mac_dig;
    logic [ACC_W-1:0]   mac_out;
    logic [POS_W-1:0]   scan_k;
    logic [7:0]         cur_byte;
    logic [7:0]         nxt_byte;
    t_result            cmd_res;

    scld_line_store #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ls_we),
        .i_waddr (r_idx),
        .i_wdata (up_byte),
        .i_clr   (ls_clr),
        .i_raddr (ls_raddr),
        .o_rdata (ls_rdata)
    );

    scld_mac u_mac (
        .i_acc (r_acc),
        .i_dig (mac_dig),
        .o_acc (mac_out)
    );

    assign out_free   = !r_out_valid || o_res.ready;
    assign i_rx.ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_rx.valid && i_rx.ready;
    assign up_byte    = ((i_rx.rx_byte >= CH_LC_A) && (i_rx.rx_byte <= CH_LC_Z))
                        ? (i_rx.rx_byte - CASE_OFS) : i_rx.rx_byte;
    assign ls_raddr   = AW'(r_col[POS_W-1:0]);
    assign scan_k     = r_col[POS_W-1:0] - 4'd1;
    assign cur_byte   = r_win[r_pos];
    assign nxt_byte   = r_win[r_pos + 4'd1];

    // Command decode from match flags, window and accumulated number
    always_comb begin
        cmd_res = '{result_kind: KIND_CMD, echo_byte: 8'h00, command_code: CMD_NONE,
                    argument: 16'h0000, read_all: 1'b0, status: ST_OK};
        if (r_match[PFX_READ_NOW]) begin
            cmd_res.command_code = CMD_READ_NOW;
        end else if (r_match[PFX_READBUF]) begin
            if (r_win[COL_COUNT] == CH_MINUS) begin
                cmd_res.command_code = CMD_READ_COUNT;
                cmd_res.read_all     = 1'b1;
            end else if (!is_digit(r_win[COL_COUNT])) begin
                cmd_res.status = ST_BAD_NUMBER;
            end else begin
                cmd_res.command_code = CMD_READ_COUNT;
                cmd_res.argument     = r_acc[15:0];
            end
        end else if (r_match[PFX_SET_T]) begin
            if (!is_digit(r_win[COL_SECONDS])) begin
                cmd_res.status = ST_BAD_NUMBER;
            end else if ((r_acc >= {1'b0, r_min}) && (r_acc <= {1'b0, r_max})) begin
                cmd_res.command_code = CMD_SET_INTERVAL;
                cmd_res.argument     = r_acc[15:0];
            end else begin
                cmd_res.status = ST_OUT_OF_RANGE;
            end
        end else if (r_match[PFX_STATE]) begin
            if (r_win[COL_STATE] == CH_O && r_win[COL_STATE + 4'd1] == CH_N) begin
                cmd_res.command_code = CMD_SAMP_ON;
            end else if (r_win[COL_STATE] == CH_O && r_win[COL_STATE + 4'd1] == CH_F
                         && r_win[COL_STATE + 4'd2] == CH_F) begin
                cmd_res.command_code = CMD_SAMP_OFF;
            end else begin
                cmd_res.status = ST_EXP_ON_OFF;
            end
        end else if (r_match[PFX_LOGGING]) begin
            if (r_win[COL_LOGGING] == CH_O && r_win[COL_LOGGING + 4'd1] == CH_N) begin
                cmd_res.command_code = CMD_LOG_ON;
            end else if (r_win[COL_LOGGING] == CH_O && r_win[COL_LOGGING + 4'd1] == CH_F
                         && r_win[COL_LOGGING + 4'd2] == CH_F) begin
                cmd_res.command_code = CMD_LOG_OFF;
            end else begin
                cmd_res.status = ST_EXP_ON_OFF;
            end
        end else if (r_match[PFX_SD]) begin
            if (r_win[COL_SD_ARG] == CH_F) begin
                cmd_res.command_code = CMD_SD_FLUSH;
            end else if (r_win[COL_SD_ARG] == CH_E) begin
                cmd_res.command_code = CMD_SD_EJECT;
            end else begin
                cmd_res.status = ST_EXP_F_E;
            end
        end else begin
            cmd_res.status = ST_UNRECOGNIZED;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_col    = r_col;
        n_win    = r_win;
        n_match  = r_match;
        n_acc    = r_acc;
        n_pos    = r_pos;
        n_is_set = r_is_set;
        n_scale  = r_scale;
        n_res    = r_res;
        load_out = 1'b0;
        ls_we    = 1'b0;
        ls_clr   = 1'b0;
        mac_dig  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_rx.rx_byte == CH_CR) begin
                        n_state = S_SCAN;
                        n_col   = '0;
                        n_match = '1;
                    end else begin
                        load_out = 1'b1;
                        n_res    = '{result_kind: KIND_ECHO, echo_byte: up_byte,
                                     command_code: CMD_NONE, argument: 16'h0000,
                                     read_all: 1'b0, status: ST_OK};
                        if (i_rx.rx_byte == CH_BS) begin
                            if (r_idx != '0) begin
                                n_idx = r_idx - AW'(1);
                            end
                        end else begin
                            ls_we = 1'b1;
                            n_idx = (r_idx == AW'(LINE_DEPTH - 1)) ? '0 : r_idx + AW'(1);
                        end
                    end
                end
            end
            S_SCAN: begin
                n_col = r_col + (POS_W + 1)'(1);
                // Data for the previous column arrives now: shift it in, drop mismatches
                if (r_col != '0) begin
                    for (int i = 0; i < WIN_LEN - 1; i++) begin
                        n_win[i] = r_win[i + 1];
                    end
                    n_win[WIN_LEN - 1] = ls_rdata;
                    for (int p = 0; p < NUM_PFX; p++) begin
                        if (scan_k < pfx_len(t_pfx'(p))
                            && ls_rdata != pfx_char(t_pfx'(p), scan_k)) begin
                            n_match[p] = 1'b0;
                        end
                    end
                end
                if (r_col == (POS_W + 1)'(WIN_LEN)) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                n_acc   = '0;
                n_scale = 1'b0;
                if (r_match[PFX_READBUF] && !r_match[PFX_READ_NOW]
                    && is_digit(r_win[COL_COUNT])) begin
                    n_pos    = COL_COUNT;
                    n_is_set = 1'b0;
                    n_state  = S_NUM;
                end else if (r_match[PFX_SET_T] && !r_match[PFX_READ_NOW]
                             && !r_match[PFX_READBUF] && is_digit(r_win[COL_SECONDS])) begin
                    n_pos    = COL_SECONDS;
                    n_is_set = 1'b1;
                    n_state  = S_NUM;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_NUM: begin
                if ((r_pos < (r_is_set ? COL_SEC_END : COL_CNT_END)) && is_digit(cur_byte)) begin
                    mac_dig = cur_byte[DIG_W-1:0];
                    n_acc   = mac_out;
                    n_pos   = r_pos + 4'd1;
                end else begin
                    n_state = r_is_set ? S_FRAC : S_DONE;
                end
            end
            S_FRAC: begin
                // Tenths digit, or zero when absent
                if (cur_byte == CH_DOT && is_digit(nxt_byte)) begin
                    mac_dig = nxt_byte[DIG_W-1:0];
                end
                n_acc   = mac_out;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                // Two more passes scale tenths of seconds to milliseconds
                n_acc   = mac_out;
                n_scale = 1'b1;
                if (r_scale) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_res    = cmd_res;
                    ls_clr   = 1'b1;
                    n_idx    = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_col       <= '0;
            r_match     <= '0;
            r_pos       <= '0;
            r_is_set    <= 1'b0;
            r_scale     <= 1'b0;
            r_out_valid <= 1'b0;
            r_min       <= MIN_IVL_RST;
            r_max       <= MAX_IVL_RST;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_col    <= n_col;
            r_match  <= n_match;
            r_pos    <= n_pos;
            r_is_set <= n_is_set;
            r_scale  <= n_scale;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_IVL: r_min <= i_cfg_data;
                    CFG_MAX_IVL: r_max <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_acc <= n_acc;
        r_res <= n_res;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_kind  = r_res.result_kind;
    assign o_res.echo_byte    = r_res.echo_byte;
    assign o_res.command_code = r_res.command_code;
    assign o_res.argument     = r_res.argument;
    assign o_res.read_all     = r_res.read_all;
    assign o_res.status       = r_res.status;

endmodule

// ===== tb/serial_command_line_decoder_core_test.sv =====
module serial_command_line_decoder_core_test
    import scld_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH    = 32;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_CYCLES  = 300;
    localparam int PHASE_BYTES   = 90;
    localparam int NUM_PHASES    = 6;

    // register indexes the block does not implement
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    scld_rx_if  rx_bus ();
    scld_res_if res_bus ();

    // line decoder state as the block should hold it
    logic [7:0]       line_text [LINE_DEPTH];
    int               wr_pos;
    logic [CFG_W-1:0] ivl_min;
    logic [CFG_W-1:0] ivl_max;

    logic [7:0] rx_backlog [$];
    logic [7:0] line_buf [$];
    t_result    expected_replies [$];

    int   bytes_queued;
    int   bytes_in_flight;
    int   mismatch_count;
    int   tx_wait;
    int   res_wait;
    int   stall_left;
    int   quiet_cycles;
    bit   tx_idle_en;
    bit   rx_idle_en;
    logic stall_request;

    serial_command_line_decoder_core #(
        .LINE_DEPTH (LINE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_bus),
        .o_res      (res_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic int digit_of(input logic [7:0] c);
        return int'(c) - int'(CH_ZERO);
    endfunction

    function automatic logic [7:0] line_col(input int k);
        return (k < LINE_DEPTH) ? line_text[k] : 8'h00;
    endfunction

    function automatic logic line_has(input string p);
        for (int k = 0; k < p.len(); k++) begin
            if (line_col(k) != p[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_line_text();
        foreach (line_text[k]) line_text[k] = 8'h00;
        wr_pos = 0;
    endfunction

    function automatic t_result decode_line();
        t_result r;
        t_cmd    cmd;
        t_status st;
        int      v;
        int      arg;
        int      i;
        r   = '0;
        cmd = CMD_NONE;
        st  = ST_OK;
        v   = 0;
        arg = 0;
        r.result_kind = KIND_CMD;
        if (line_has("READ NOW")) begin
            cmd = CMD_READ_NOW;
        end else if (line_has("READBUFFER")) begin
            if (line_col(11) == CH_MINUS) begin
                cmd = CMD_READ_COUNT;
                r.read_all = 1'b1;
            end else if (!is_dec(line_col(11))) begin
                st = ST_BAD_NUMBER;
            end else begin
                for (i = 11; i < 15 && is_dec(line_col(i)); i++) v = v * 10 + digit_of(line_col(i));
                cmd = CMD_READ_COUNT;
                arg = v;
            end
        end else if (line_has("SET T")) begin
            if (!is_dec(line_col(6))) begin
                st = ST_BAD_NUMBER;
            end else begin
                i = 6;
                while (i < 8 && is_dec(line_col(i))) begin
                    v = v * 10 + digit_of(line_col(i)) * 1000;
                    i++;
                end
                if (line_col(i) == CH_DOT && is_dec(line_col(i + 1)))
                    v = v + digit_of(line_col(i + 1)) * 100;
                if (v >= int'(ivl_min) && v <= int'(ivl_max)) begin
                    cmd = CMD_SET_INTERVAL;
                    arg = v;
                end else begin
                    st = ST_OUT_OF_RANGE;
                end
            end
        end else if (line_has("STATE")) begin
            if (line_col(6) == CH_O && line_col(7) == CH_N)
                cmd = CMD_SAMP_ON;
            else if (line_col(6) == CH_O && line_col(7) == CH_F && line_col(8) == CH_F)
                cmd = CMD_SAMP_OFF;
            else
                st = ST_EXP_ON_OFF;
        end else if (line_has("LOGGING")) begin
            if (line_col(8) == CH_O && line_col(9) == CH_N)
                cmd = CMD_LOG_ON;
            else if (line_col(8) == CH_O && line_col(9) == CH_F && line_col(10) == CH_F)
                cmd = CMD_LOG_OFF;
            else
                st = ST_EXP_ON_OFF;
        end else if (line_has("SD")) begin
            if (line_col(3) == CH_F)
                cmd = CMD_SD_FLUSH;
            else if (line_col(3) == CH_E)
                cmd = CMD_SD_EJECT;
            else
                st = ST_EXP_F_E;
        end else begin
            st = ST_UNRECOGNIZED;
        end
        r.command_code = cmd;
        r.argument     = arg[15:0];
        r.status       = st;
        return r;
    endfunction

    function automatic t_result decode_byte(input logic [7:0] b);
        t_result    r;
        logic [7:0] c;
        r = '0;
        c = b;
        if (b == CH_CR) begin
            r = decode_line();
            clear_line_text();
        end else begin
            if (b == CH_BS) begin
                if (wr_pos > 0) wr_pos--;
            end else begin
                if (c >= CH_LC_A && c <= CH_LC_Z) c = c - CASE_OFS;
                line_text[wr_pos] = c;
                wr_pos = (wr_pos + 1) % LINE_DEPTH;
            end
            r.echo_byte = c;
        end
        return r;
    endfunction

    task automatic report_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_reply();
        t_result want;
        if (expected_replies.size() == 0) begin
            $display("%0t: result with none expected, got kind %0d echo %0d code %0d status %0d",
                     $time, res_bus.result_kind, res_bus.echo_byte, res_bus.command_code,
                     res_bus.status);
            mismatch_count++;
        end else begin
            want = expected_replies.pop_front();
            report_field("result_kind", want.result_kind, res_bus.result_kind);
            report_field("echo_byte", want.echo_byte, res_bus.echo_byte);
            report_field("command_code", want.command_code, res_bus.command_code);
            report_field("argument", want.argument, res_bus.argument);
            report_field("read_all", want.read_all, res_bus.read_all);
            report_field("status", want.status, res_bus.status);
        end
    endtask

    // byte source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_bus.valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (rx_bus.valid && rx_bus.ready) begin
                expected_replies.push_back(decode_byte(rx_bus.rx_byte));
                bytes_in_flight--;
                tx_wait = tx_idle_en ? $urandom_range(0, 4) : 0;
            end
            if (!rx_bus.valid || rx_bus.ready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    rx_bus.valid <= 1'b0;
                end else if (rx_backlog.size() > 0) begin
                    rx_bus.valid   <= 1'b1;
                    rx_bus.rx_byte <= rx_backlog.pop_front();
                end else begin
                    rx_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result sink
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            res_wait   = 0;
            stall_left = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                check_reply();
                res_wait = rx_idle_en ? $urandom_range(0, 4) : 0;
            end
            if (stall_request) begin
                stall_left = STALL_CYCLES;
                stall_request <= 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end else if (res_wait > 0) begin
                res_wait--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put_byte(input logic [7:0] b);
        line_buf.push_back(b);
    endtask

    // mix in lower case now and then
    task automatic put(input string s);
        logic [7:0] c;
        for (int k = 0; k < s.len(); k++) begin
            c = s[k];
            if (c >= 8'd65 && c <= 8'd90 && $urandom_range(0, 3) == 0) c = c + CASE_OFS;
            line_buf.push_back(c);
        end
    endtask

    task automatic end_line();
        line_buf.push_back(CH_CR);
        bytes_queued    += line_buf.size();
        bytes_in_flight += line_buf.size();
        while (line_buf.size() > 0) rx_backlog.push_back(line_buf.pop_front());
    endtask

    function automatic string rand_digits(input int n);
        string s;
        s = "";
        for (int k = 0; k < n; k++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        return s;
    endfunction

    function automatic string rand_char();
        return $sformatf("%c", $urandom_range(33, 126));
    endfunction

    function automatic string pick_on_off();
        case ($urandom_range(0, 5))
            0, 1:    return "ON";
            2, 3:    return "OFF";
            4:       return "OF";
            default: return {rand_char(), rand_char()};
        endcase
    endfunction

    task automatic put_command();
        string sep;
        sep = ($urandom_range(0, 4) == 0) ? rand_char() : " ";
        case ($urandom_range(0, 6))
            0: begin
                put("READ NOW");
                if ($urandom_range(0, 2) == 0) put(rand_char());
            end
            1: begin
                put({"READBUFFER", sep});
                case ($urandom_range(0, 3))
                    0:       put("-");
                    3:       put(rand_char());
                    default: put(rand_digits($urandom_range(1, 5)));
                endcase
            end
            2, 3: begin
                put({"SET T", sep});
                put(rand_digits($urandom_range(0, 3)));
                if ($urandom_range(0, 1) == 0) begin
                    put(".");
                    put(rand_digits($urandom_range(0, 1)));
                end
            end
            4: begin
                put({"STATE", sep});
                put(pick_on_off());
            end
            5: begin
                put({"LOGGING", sep});
                put(pick_on_off());
            end
            default: begin
                put({"SD", sep});
                case ($urandom_range(0, 2))
                    0:       put("F");
                    1:       put("E");
                    default: put(rand_char());
                endcase
            end
        endcase
    endtask

    task automatic queue_random_line();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            n = $urandom_range(0, 40);
            for (int k = 0; k < n; k++) put_byte(8'($urandom_range(0, 255)));
        end else begin
            // overflow: the command lands on the wrapped index
            if (sel < 20) begin
                n = $urandom_range(0, 1) ? LINE_DEPTH : $urandom_range(LINE_DEPTH + 1, 44);
                for (int k = 0; k < n; k++) put_byte(8'($urandom_range(33, 126)));
            end
            put_command();
            // typo fixed by backspace leaves stale bytes behind
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++) put(rand_char());
                n = $urandom_range(0, 4);
                for (int k = 0; k < n; k++) put_byte(CH_BS);
            end
        end
        end_line();
    endtask

    task automatic settle();
        while (bytes_in_flight != 0 || expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MIN_IVL)
            ivl_min = val;
        else if (idx == CFG_MAX_IVL)
            ivl_max = val;
    endtask

    initial begin
        int phase;
        int mark;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_MIN_IVL;
        cfg_data       = '0;
        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = '0;
        res_bus.ready  = 1'b0;
        stall_request  = 1'b0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        clear_line_text();
        ivl_min = MIN_IVL_RST;
        ivl_max = MAX_IVL_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            case (phase)
                1: begin
                    cfg_write(CFG_MIN_IVL, 16'd0);
                    cfg_write(CFG_MAX_IVL, 16'hFFFF);
                    cfg_write(CFG_SPARE_A, 16'h1234);
                    cfg_write(CFG_SPARE_B, 16'h0000);
                    tx_idle_en = 1'b0;
                    rx_idle_en = 1'b0;
                end
                2: begin
                    cfg_write(CFG_MIN_IVL, 16'hFFFF);
                    cfg_write(CFG_MAX_IVL, 16'hFFFF);
                end
                3: begin
                    cfg_write(CFG_MIN_IVL, 16'd12000);
                    cfg_write(CFG_MAX_IVL, 16'd12000);
                    tx_idle_en = 1'b1;
                end
                4: begin
                    cfg_write(CFG_MAX_IVL, 16'd0);
                    cfg_write(CFG_MIN_IVL, 16'd0);
                    tx_idle_en = 1'b0;
                    rx_idle_en = 1'b1;
                end
                5: begin
                    cfg_write(CFG_MIN_IVL, 16'd1000);
                    cfg_write(CFG_MAX_IVL, 16'd2500);
                    tx_idle_en = 1'b1;
                end
                default: begin
                    // reset values of the interval limits
                    put_byte(CH_BS);
                    put("read now");
                    end_line();
                    put("READBUFFER -");
                    end_line();
                    put("READBUFFER 9999");
                    end_line();
                    put("READBUFFER 12345");
                    end_line();
                    put("READBUFFER X");
                    end_line();
                    put("SET T 0.1");
                    end_line();
                    put("SET T 30");
                    end_line();
                    put("SET T 30.1");
                    end_line();
                    put("SET T 9.X");
                    end_line();
                    put("SET T .");
                    end_line();
                    put("STATE ON");
                    end_line();
                    put("STATE OFF");
                    end_line();
                    put("STATE OF");
                    end_line();
                    put("LOGGING ON");
                    end_line();
                    put("LOGGING OFF");
                    end_line();
                    put("LOGGING X");
                    end_line();
                    put("SD F");
                    put_byte(CH_BS);
                    put_byte(CH_BS);
                    end_line();
                    put("SD E");
                    end_line();
                    put("SD Q");
                    end_line();
                    put("HELLO");
                    end_line();
                    end_line();
                    put_byte(8'h00);
                    put("SD F");
                    end_line();
                    put_byte(8'hFF);
                    put_byte(8'h7F);
                    end_line();
                    for (int k = 0; k < LINE_DEPTH; k++) put("Z");
                    put("SD E");
                    end_line();
                    put("READ NOW");
                    for (int k = 0; k < 8; k++) put_byte(CH_BS);
                    put("SD F");
                    end_line();
                end
            endcase
            mark = bytes_queued;
            while (bytes_queued - mark < PHASE_BYTES) queue_random_line();
            if (phase == 2) begin
                // hold results off while bytes keep coming
                @(posedge i_clk);
                stall_request <= 1'b1;
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
